/* src/dmdt_pkg.sv */
package dmdt_pkg;

	// counter width in 32-bit size mode (16 to 32)
	localparam int COUNTER_WIDTH = 32;

	// command codes
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	// register selects
	localparam logic [2:0] REG_LOAD   = 3'd0;
	localparam logic [2:0] REG_VALUE  = 3'd1;
	localparam logic [2:0] REG_CTRL   = 3'd2;
	localparam logic [2:0] REG_INTCLR = 3'd3;
	localparam logic [2:0] REG_RIS    = 3'd4;
	localparam logic [2:0] REG_MIS    = 3'd5;
	localparam logic [2:0] REG_BGLOAD = 3'd6;

	// control word bits
	localparam int CTL_ONESHOT  = 0;
	localparam int CTL_SIZE     = 1;
	localparam int CTL_PRE_LO   = 2;
	localparam int CTL_PRE_HI   = 3;
	localparam int CTL_IE       = 5;
	localparam int CTL_PERIODIC = 6;
	localparam int CTL_ENABLE   = 7;
	localparam logic [7:0] CTL_WRITABLE = 8'hEF;
	localparam logic [7:0] CTL_RESET    = 8'h20;

	// prescale codes
	localparam logic [1:0] PRE_DIV1  = 2'd0;
	localparam logic [1:0] PRE_DIV16 = 2'd1;

	localparam logic [COUNTER_WIDTH-1:0] WIDE_MASK = '1;
	localparam logic [COUNTER_WIDTH-1:0] HALF_MASK = COUNTER_WIDTH'(32'h0000FFFF);

	typedef struct packed {
		logic [1:0]  cmd;
		logic [2:0]  reg_sel;
		logic [31:0] write_data;
	} in_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq;
		logic        zero_event;
	} out_t;

endpackage

/* src/dmdt_core.sv */
module dmdt_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  dmdt_pkg::in_t item,
	output dmdt_pkg::out_t result
);

	localparam int CW = dmdt_pkg::COUNTER_WIDTH;

	logic [CW-1:0] count_q;
	logic [CW-1:0] reload_q;
	logic [7:0]    ctrl_q;
	logic [7:0]    pre_q;
	logic          flag_q;

	logic [CW-1:0] count_d;
	logic [CW-1:0] reload_d;
	logic [7:0]    ctrl_d;
	logic [7:0]    pre_d;
	logic          flag_d;

	logic [CW-1:0] mask;
	logic [CW-1:0] cur;
	logic [CW-1:0] dec;
	logic [7:0]    div_m1;
	logic [CW-1:0] wr_val;
	logic          event_tick;
	logic [CW-1:0] count_tick;
	logic [31:0]   rd;
	logic          ev;

	// active width and prescale divisor from the control word
	always_comb begin
		mask = ctrl_q[dmdt_pkg::CTL_SIZE] ? dmdt_pkg::WIDE_MASK : dmdt_pkg::HALF_MASK;
		cur  = count_q & mask;
		dec  = (cur - CW'(1)) & mask;
		case (ctrl_q[dmdt_pkg::CTL_PRE_HI:dmdt_pkg::CTL_PRE_LO])
			dmdt_pkg::PRE_DIV1:  div_m1 = 8'd0;
			dmdt_pkg::PRE_DIV16: div_m1 = 8'd15;
			default:             div_m1 = 8'd255;
		endcase
		wr_val = item.write_data[CW-1:0];
	end

	// one prescaled count step: decrement, reload, wrap or halt
	always_comb begin
		count_tick = count_q;
		event_tick = 1'b0;
		if (cur == '0) begin
			if (ctrl_q[dmdt_pkg::CTL_ONESHOT]) begin
				count_tick = count_q;
			end else if (ctrl_q[dmdt_pkg::CTL_PERIODIC]) begin
				count_tick = reload_q;
				event_tick = (reload_q & mask) == '0;
			end else begin
				count_tick = mask;
			end
		end else begin
			count_tick = dec;
			event_tick = dec == '0;
		end
	end

	// next state and read data for the current transaction
	always_comb begin
		count_d  = count_q;
		reload_d = reload_q;
		ctrl_d   = ctrl_q;
		pre_d    = pre_q;
		flag_d   = flag_q;
		rd       = '0;
		ev       = 1'b0;
		case (item.cmd)
			dmdt_pkg::CMD_TICK: begin
				if (ctrl_q[dmdt_pkg::CTL_ENABLE]) begin
					if (pre_q >= div_m1) begin
						pre_d   = '0;
						count_d = count_tick;
						ev      = event_tick;
						if (event_tick) begin
							flag_d = 1'b1;
						end
					end else begin
						pre_d = pre_q + 8'd1;
					end
				end
			end
			dmdt_pkg::CMD_WRITE: begin
				case (item.reg_sel)
					dmdt_pkg::REG_LOAD: begin
						reload_d = wr_val;
						count_d  = wr_val;
					end
					dmdt_pkg::REG_CTRL: begin
						ctrl_d = item.write_data[7:0] & dmdt_pkg::CTL_WRITABLE;
					end
					dmdt_pkg::REG_INTCLR: begin
						flag_d = 1'b0;
					end
					dmdt_pkg::REG_BGLOAD: begin
						reload_d = wr_val;
					end
					default: begin
					end
				endcase
			end
			dmdt_pkg::CMD_READ: begin
				case (item.reg_sel)
					dmdt_pkg::REG_LOAD:   rd = 32'(reload_q);
					dmdt_pkg::REG_VALUE:  rd = 32'(count_q);
					dmdt_pkg::REG_CTRL:   rd = 32'(ctrl_q);
					dmdt_pkg::REG_RIS:    rd = 32'(flag_q);
					dmdt_pkg::REG_MIS:    rd = 32'(flag_q & ctrl_q[dmdt_pkg::CTL_IE]);
					dmdt_pkg::REG_BGLOAD: rd = 32'(reload_q);
					default:              rd = '0;
				endcase
			end
			default: begin
			end
		endcase
	end

	assign result.read_data  = rd;
	assign result.irq        = flag_d & ctrl_d[dmdt_pkg::CTL_IE];
	assign result.zero_event = ev;

	// timer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= dmdt_pkg::WIDE_MASK;
			reload_q <= '0;
			ctrl_q   <= dmdt_pkg::CTL_RESET;
			pre_q    <= '0;
			flag_q   <= 1'b0;
		end else if (step) begin
			count_q  <= count_d;
			reload_q <= reload_d;
			ctrl_q   <= ctrl_d;
			pre_q    <= pre_d;
			flag_q   <= flag_d;
		end
	end

endmodule

/* src/dmdt_obuf.sv */
module dmdt_obuf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dmdt_pkg::out_t push_data,
	output logic           can_take,
	output logic           valid,
	input  logic           ready,
	output dmdt_pkg::out_t data
);

	logic           valid_q;
	dmdt_pkg::out_t data_q;

	// free when empty or when the held transaction leaves this cycle
	assign can_take = !valid_q || ready;
	assign valid    = valid_q;
	assign data     = data_q;

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_take) begin
			valid_q <= push;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (push && can_take) begin
			data_q <= push_data;
		end
	end

endmodule

/* src/dual_mode_down_counter_timer_top.sv */
// Down-counting timer, one channel. Each input transaction is a prescaler tick, a register
// write or a register read, and each gives exactly one result transaction carrying read data,
// the masked interrupt line and a zero event. An accepted transaction is held in an input
// register and resolved against the timer state when it moves on to the result register, where
// it is held until the output side is ready; one transaction is taken every cycle while the
// output is not stalled. The timer registers are updated as each transaction moves on; a
// stalled output holds the input side once both registers are full.
module dual_mode_down_counter_timer_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  dmdt_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output dmdt_pkg::out_t out_data
);

	logic           valid_s1;
	dmdt_pkg::in_t  item_s1;
	logic           advance;
	logic           can_take;
	dmdt_pkg::out_t core_res;

	// stage one moves on when the result register can take it
	assign advance  = valid_s1 && can_take;
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	// timer state and per-transaction logic
	dmdt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (core_res)
	);

	// result register
	dmdt_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.push_data (core_res),
		.can_take  (can_take),
		.valid     (out_valid),
		.ready     (out_ready),
		.data      (out_data)
	);

`ifndef SYNTHESIS
	// only a tick can raise the zero event
	a_event_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.cmd != dmdt_pkg::CMD_TICK) |-> !core_res.zero_event)
		else $error("zero event on a non-tick transaction");

	// read data is zero for anything but a read
	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.cmd != dmdt_pkg::CMD_READ) |-> core_res.read_data == 32'd0)
		else $error("read data on a non-read transaction");

	// a transaction leaving stage one shows up as a result
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("result lost after stage one");

	// stage one never takes a transaction while full and blocked
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !can_take) |-> !in_ready)
		else $error("input register overrun");
`endif

endmodule
